// ----- src/usrsm_pkg.sv -----
// ----------------------------------------------------------------------------
// usrsm_pkg
// Shared types and constants for the usart register and status model: the
// command codes, register indexes, status and control bit positions.
// ----------------------------------------------------------------------------
package usrsm_pkg;

    localparam int DEFAULT_RX_FIFO_DEPTH = 16;

    localparam int NUM_REGS = 7;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RX_BYTE = 2'd2,
        CMD_IDLE    = 2'd3
    } cmd_t;

    localparam logic [2:0] REG_SR   = 3'd0;
    localparam logic [2:0] REG_DR   = 3'd1;
    localparam logic [2:0] REG_BRR  = 3'd2;
    localparam logic [2:0] REG_CR1  = 3'd3;
    localparam logic [2:0] REG_CR2  = 3'd4;
    localparam logic [2:0] REG_CR3  = 3'd5;
    localparam logic [2:0] REG_GTPR = 3'd6;

    // status bits
    localparam int SR_ORE  = 3;
    localparam int SR_IDLE = 4;
    localparam int SR_RXNE = 5;
    localparam int SR_TC   = 6;
    localparam int SR_TXE  = 7;

    // control bits
    localparam int CR1_RE     = 2;
    localparam int CR1_IDLEIE = 4;
    localparam int CR1_RXNEIE = 5;
    localparam int CR1_TCIE   = 6;
    localparam int CR1_TXEIE  = 7;
    localparam int CR1_UE     = 13;
    localparam int CR3_DMAR   = 6;

    localparam logic [31:0] SR_RESET      = 32'h0000_00c0;
    localparam logic [31:0] SR_CLEAR_ONLY = 32'h0000_0360;
    localparam int          DR_DATA_BITS  = 9;

    typedef struct packed {
        cmd_t        command;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [7:0]  tx_byte2;
        logic        two;
        logic        irq;
        logic        dma_request;
        logic        rx_dropped;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

endpackage

// ----- src/usrsm_rx_fifo.sv -----
// ----------------------------------------------------------------------------
// usrsm_rx_fifo
// Receive byte queue: circular buffer with registered read of the next head
// entry, a write bypass and pass-through when a byte is pushed and popped
// while empty.
// ----------------------------------------------------------------------------
module usrsm_rx_fifo
    import usrsm_pkg::*;
#(
    parameter int RX_FIFO_DEPTH = DEFAULT_RX_FIFO_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fifo_ctl_t                          ctl,
    input  logic [7:0]                         push_data,
    output logic [7:0]                         pop_data,
    output logic [$clog2(RX_FIFO_DEPTH+1)-1:0] count
);

    localparam int PW = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam int CW = $clog2(RX_FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(RX_FIFO_DEPTH - 1);

    logic [7:0]    mem [RX_FIFO_DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    rd_data_reg;
    logic          byp_reg;
    logic [7:0]    byp_data_reg;
    logic          empty;
    logic          wr_en;
    logic          rd_en;
    logic [7:0]    front;

    assign empty = (count_reg == '0);
    assign wr_en = ctl.push && !(ctl.pop && empty);
    assign rd_en = ctl.pop && !empty;
    assign front = byp_reg ? byp_data_reg : rd_data_reg;
    assign pop_data = empty ? push_data : front;
    assign count = count_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (rd_en) begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + PW'(1);
        end
        if (wr_en) begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + PW'(1);
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + CW'(1);
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= push_data;
        end
        rd_data_reg  <= mem[head_next];
        byp_reg      <= wr_en && (tail_reg == head_next);
        byp_data_reg <= push_data;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(RX_FIFO_DEPTH))
        else $error("rx fifo count beyond depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.push && count_reg == CW'(RX_FIFO_DEPTH)) |-> 1'b0)
        else $error("push into full rx fifo");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.pop && empty) |-> ctl.push)
        else $error("pop from empty rx fifo without pass-through");
`endif

endmodule

// ----- src/usrsm_core.sv -----
// ----------------------------------------------------------------------------
// usrsm_core
// Register file, transmit holding register and status flag logic. Works one
// request per cycle while fire is high; drives fifo controls and the result.
// ----------------------------------------------------------------------------
module usrsm_core
    import usrsm_pkg::*;
#(
    parameter int RX_FIFO_DEPTH = DEFAULT_RX_FIFO_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               fire,
    input  item_t                              item,
    input  logic [$clog2(RX_FIFO_DEPTH+1)-1:0] fifo_count,
    input  logic [7:0]                         fifo_data,
    output fifo_ctl_t                          ctl,
    output result_t                            res
);

    localparam int CW = $clog2(RX_FIFO_DEPTH + 1);

    logic [31:0] regs_reg [NUM_REGS];
    logic [31:0] regs_next [NUM_REGS];
    logic [8:0]  txh_reg, txh_next;
    logic        seen_ore_reg, seen_ore_next;
    logic        seen_idle_reg, seen_idle_next;

    logic        idx_ok;
    logic [2:0]  ridx;
    logic        rx_en;
    logic        do_fill;
    logic        fill_nonempty;
    logic [31:0] wd_m;
    logic [31:0] sr_n;
    logic [31:0] cr1_n;

    assign ridx   = item.reg_index[2:0];
    assign idx_ok = !item.reg_index[3] && (ridx != 3'd7);
    assign rx_en  = regs_reg[REG_CR1][CR1_UE] && regs_reg[REG_CR1][CR1_RE];

    always_comb begin
        regs_next      = regs_reg;
        txh_next       = txh_reg;
        seen_ore_next  = seen_ore_reg;
        seen_idle_next = seen_idle_reg;
        ctl            = '0;
        res            = '0;
        do_fill        = 1'b0;
        fill_nonempty  = (fifo_count != '0);
        wd_m           = item.write_data;
        case (item.command)
            CMD_READ: begin
                if (idx_ok) begin
                    case (ridx)
                        REG_SR: begin
                            if (regs_reg[REG_SR][SR_ORE]) begin
                                seen_ore_next = 1'b1;
                            end
                            if (regs_reg[REG_SR][SR_IDLE]) begin
                                seen_idle_next = 1'b1;
                            end
                            res.read_data = regs_reg[REG_SR];
                        end
                        REG_DR: begin
                            if (regs_reg[REG_SR][SR_ORE] && seen_ore_reg) begin
                                regs_next[REG_SR][SR_ORE] = 1'b0;
                            end
                            if (seen_idle_reg) begin
                                regs_next[REG_SR][SR_IDLE] = 1'b0;
                                seen_idle_next = 1'b0;
                            end
                            if (regs_reg[REG_SR][SR_RXNE]) begin
                                regs_next[REG_SR][SR_RXNE] = 1'b0;
                                res.read_data = {24'd0, regs_reg[REG_DR][7:0]};
                                do_fill = 1'b1;
                            end else begin
                                regs_next[REG_DR][DR_DATA_BITS-1:0] = '0;
                            end
                        end
                        default: begin
                            seen_idle_next = 1'b0;
                            res.read_data  = regs_reg[ridx];
                        end
                    endcase
                end
            end
            CMD_WRITE: begin
                if (idx_ok) begin
                    case (ridx)
                        REG_SR: begin
                            if ((item.write_data & ~regs_reg[REG_SR] & SR_CLEAR_ONLY) != '0)
                            begin
                                wd_m = item.write_data | SR_CLEAR_ONLY;
                            end
                            regs_next[REG_SR] = regs_reg[REG_SR] & wd_m;
                        end
                        REG_DR: begin
                            if (regs_reg[REG_SR][SR_TC]) begin
                                res.tx_valid = 1'b1;
                                res.tx_byte  = item.write_data[7:0];
                                if (!regs_reg[REG_SR][SR_TXE]) begin
                                    res.two      = 1'b1;
                                    res.tx_byte2 = txh_reg[7:0];
                                end
                                regs_next[REG_SR][SR_TXE] = 1'b1;
                                regs_next[REG_SR][SR_TC]  = 1'b1;
                            end else if (regs_reg[REG_SR][SR_TXE]) begin
                                txh_next = item.write_data[DR_DATA_BITS-1:0];
                                regs_next[REG_SR][SR_TXE] = 1'b0;
                            end
                        end
                        default: begin
                            regs_next[ridx] = item.write_data;
                        end
                    endcase
                end
            end
            CMD_RX_BYTE: begin
                if (fifo_count < CW'(RX_FIFO_DEPTH)) begin
                    ctl.push      = 1'b1;
                    fill_nonempty = 1'b1;
                end else begin
                    res.rx_dropped = 1'b1;
                end
                do_fill = 1'b1;
            end
            CMD_IDLE: begin
                regs_next[REG_SR][SR_IDLE] = 1'b1;
            end
            default: begin
            end
        endcase

        // refill receive data register from the fifo
        if (do_fill && fill_nonempty && !(rx_en && regs_next[REG_SR][SR_RXNE])) begin
            ctl.pop = 1'b1;
            if (rx_en) begin
                regs_next[REG_DR][DR_DATA_BITS-1:0] = {1'b0, fifo_data};
                regs_next[REG_SR][SR_RXNE] = 1'b1;
            end
        end

        sr_n  = regs_next[REG_SR];
        cr1_n = regs_next[REG_CR1];
        res.irq = (sr_n[SR_TC] && cr1_n[CR1_TCIE])
               || (sr_n[SR_IDLE] && cr1_n[CR1_IDLEIE])
               || (sr_n[SR_TXE] && cr1_n[CR1_TXEIE])
               || (cr1_n[CR1_RXNEIE] && (sr_n[SR_ORE] || sr_n[SR_RXNE]));
        res.dma_request = sr_n[SR_RXNE] && regs_next[REG_CR3][CR3_DMAR];

        if (!fire) begin
            ctl = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= '0;
            end
            regs_reg[REG_SR] <= SR_RESET;
            txh_reg          <= '0;
            seen_ore_reg     <= 1'b0;
            seen_idle_reg    <= 1'b0;
        end else if (fire) begin
            regs_reg      <= regs_next;
            txh_reg       <= txh_next;
            seen_ore_reg  <= seen_ore_next;
            seen_idle_reg <= seen_idle_next;
        end
    end

`ifndef SYNTHESIS
    a_drop_only_rx: assert property (@(posedge aclk) disable iff (!aresetn)
        res.rx_dropped |-> (item.command == CMD_RX_BYTE && !ctl.push))
        else $error("drop flagged outside a full-fifo receive");

    a_two_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        res.two |-> (res.tx_valid && item.command == CMD_WRITE))
        else $error("second transmit without a first");
`endif

endmodule

// ----- src/usrsm_out_stage.sv -----
// ----------------------------------------------------------------------------
// usrsm_out_stage
// Result register. Holds one request's result and splits a double transmit
// into two results, the second marked last.
// ----------------------------------------------------------------------------
module usrsm_out_stage
    import usrsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     res,
    output logic        out_free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_irq,
    output logic        m_dma_request,
    output logic        m_rx_dropped,
    output logic        m_last
);

    logic       out_valid_reg;
    logic       last_reg;
    result_t    res_reg;
    logic [7:0] tx_byte_reg;

    assign out_free      = !out_valid_reg || (m_ready && last_reg);
    assign m_valid       = out_valid_reg;
    assign m_read_data   = res_reg.read_data;
    assign m_tx_valid    = res_reg.tx_valid;
    assign m_tx_byte     = tx_byte_reg;
    assign m_irq         = res_reg.irq;
    assign m_dma_request = res_reg.dma_request;
    assign m_rx_dropped  = res_reg.rx_dropped;
    assign m_last        = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b1;
        end else if (load) begin
            out_valid_reg <= 1'b1;
            last_reg      <= !res.two;
        end else if (out_valid_reg && m_ready) begin
            if (last_reg) begin
                out_valid_reg <= 1'b0;
            end else begin
                last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg     <= res;
            tx_byte_reg <= res.tx_byte;
        end else if (out_valid_reg && m_ready && !last_reg) begin
            tx_byte_reg <= res_reg.tx_byte2;
        end
    end

`ifndef SYNTHESIS
    a_first_of_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !last_reg) |-> res_reg.tx_valid)
        else $error("non-last result without a transmit");

    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !last_reg && m_ready) |=> (out_valid_reg && last_reg))
        else $error("second transmit result lost");
`endif

endmodule

// ----- src/usart_register_status_model.sv -----
// ----------------------------------------------------------------------------
// usart_register_status_model
// Register and status model of a usart: word bus reads and writes, received
// bytes and idle-timeout events in; read data, sent bytes, irq and dma out.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (valid/ready) with a command, a register
// index, write data and a received byte. Each request gives one result on the
// m_ channel, or two when a DR write sends both the new byte and the held one;
// m_last marks the final result of a request.
// An accepted request sits in the input register and passes the register and
// flag logic into the result register, which drives m_valid.
// Throughput is one request per cycle while m_ready stays high, set by the
// result register, which holds a two-result request until both are taken.
// While the receiver holds m_ready low the result register keeps its result,
// the input register takes one more request and then s_ready drops.
// Reset (aresetn low, synchronous) clears SR to 0xC0 and all other registers,
// the transmit holding register, the seen-flags and the receive fifo count.
// Receive fifo contents are not cleared.
// ----------------------------------------------------------------------------
module usart_register_status_model
    import usrsm_pkg::*;
#(
    parameter int RX_FIFO_DEPTH = DEFAULT_RX_FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [3:0]  s_reg_index,
    input  logic [31:0] s_write_data,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_irq,
    output logic        m_dma_request,
    output logic        m_rx_dropped,
    output logic        m_last
);

    localparam int CW = $clog2(RX_FIFO_DEPTH + 1);

    logic          in_valid_reg;
    item_t         item_reg;
    logic          out_free;
    logic          fire;
    fifo_ctl_t     fifo_ctl;
    logic [7:0]    fifo_data;
    logic [CW-1:0] fifo_count;
    result_t       res;

    assign fire    = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.command    <= cmd_t'(s_command);
            item_reg.reg_index  <= s_reg_index;
            item_reg.write_data <= s_write_data;
            item_reg.rx_byte    <= s_rx_byte;
        end
    end

    usrsm_rx_fifo #(
        .RX_FIFO_DEPTH (RX_FIFO_DEPTH)
    ) u_rx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (fifo_ctl),
        .push_data (item_reg.rx_byte),
        .pop_data  (fifo_data),
        .count     (fifo_count)
    );

    usrsm_core #(
        .RX_FIFO_DEPTH (RX_FIFO_DEPTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (item_reg),
        .fifo_count (fifo_count),
        .fifo_data  (fifo_data),
        .ctl        (fifo_ctl),
        .res        (res)
    );

    usrsm_out_stage u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (fire),
        .res           (res),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_tx_valid    (m_tx_valid),
        .m_tx_byte     (m_tx_byte),
        .m_irq         (m_irq),
        .m_dma_request (m_dma_request),
        .m_rx_dropped  (m_rx_dropped),
        .m_last        (m_last)
    );

endmodule

// ----- tb/usart_register_status_model_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usart_register_status_model_tb
// Self-checking bench for the usart register and status model. A short table
// of bus accesses, received bytes and idle events walks reset values, invalid
// indexes, transmit, receive and flag clearing; shaped random traffic (receive
// bursts, drains, idle sequences, register traffic) follows, then a closing
// table shuts the transmitter down. Typed rows are checked against the table;
// others against an in-bench prediction of regs, holding register, receive fifo.
// ----------------------------------------------------------------------------
module usart_register_status_model_tb
    import usrsm_pkg::*;
();

    localparam int          RX_DEPTH       = DEFAULT_RX_FIFO_DEPTH;
    localparam int          RANDOM_ITEMS   = 700;
    localparam int          QUIET_ITEMS    = 150;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int          NUM_DIR        = 35;
    localparam int          SHUTDOWN_ROW   = 25;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [3:0]  IDX_SR         = 4'(REG_SR);
    localparam logic [3:0]  IDX_DR         = 4'(REG_DR);
    localparam logic [3:0]  IDX_BRR        = 4'(REG_BRR);
    localparam logic [3:0]  IDX_CR1        = 4'(REG_CR1);
    localparam logic [3:0]  IDX_CR2        = 4'(REG_CR2);
    localparam logic [3:0]  IDX_CR3        = 4'(REG_CR3);
    localparam logic [3:0]  IDX_GTPR       = 4'(REG_GTPR);
    localparam logic [3:0]  IDX_BAD_FIRST  = 4'd7;
    localparam logic [3:0]  IDX_BAD_TOP    = 4'd15;
    localparam logic [31:0] DR_DATA_MASK   = (32'd1 << DR_DATA_BITS) - 32'd1;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq;
        logic        dma_request;
        logic        rx_dropped;
        logic        last;
    } usart_resp_t;

    typedef struct packed {
        item_t       req;
        logic        typed;
        logic [31:0] want_rd;
        logic        want_irq;
        logic        want_dma;
    } dir_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command     = 2'd0;
    logic [3:0]  s_reg_index   = 4'd0;
    logic [31:0] s_write_data  = 32'd0;
    logic [7:0]  s_rx_byte     = 8'd0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [31:0] m_read_data;
    logic        m_tx_valid;
    logic [7:0]  m_tx_byte;
    logic        m_irq;
    logic        m_dma_request;
    logic        m_rx_dropped;
    logic        m_last;

    // predicted block state
    logic [31:0] regs_m [NUM_REGS];
    logic [8:0]  tx_hold_m;
    logic [7:0]  rx_fifo_m [$];
    logic        seen_ore_m;
    logic        seen_idle_m;

    usart_resp_t pending_resp_q [$];
    usart_resp_t got_resp;
    usart_resp_t want_resp;
    bit          calm            = 1'b0;
    int          request_count   = 0;
    int          result_count    = 0;
    int          tx_count        = 0;
    int          drop_count      = 0;
    int          fifo_peak       = 0;
    int          mismatch_count  = 0;
    int          cycle_count     = 0;
    int          stall_left      = 0;

    dir_row_t dir_rows [NUM_DIR] = '{
        '{'{CMD_READ,    IDX_SR,        32'h0000_0000, 8'h00}, 1'b1, 32'h0000_00c0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_DR,        32'h0000_0000, 8'h00}, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_BAD_TOP,   32'hffff_ffff, 8'hff}, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_BAD_FIRST, 32'hffff_ffff, 8'h00}, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_CR3,       32'hffff_ffff, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_CR3,       32'h0000_0000, 8'h00}, 1'b1, 32'hffff_ffff, 1'b0, 1'b0},
        '{'{CMD_RX_BYTE, IDX_SR,        32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_DR,        32'h0000_0000, 8'h00}, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_BRR,       32'hffff_ffff, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_BRR,       32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_CR2,       32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_GTPR,      32'ha5a5_5a5a, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_GTPR,      32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_CR1,       32'h0000_20f4, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_DR,        32'h0000_01ff, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_DR,        32'hffff_fd00, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_RX_BYTE, IDX_DR,        32'h0000_0000, 8'hff}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_RX_BYTE, IDX_DR,        32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_IDLE,    IDX_SR,        32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_SR,        32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_DR,        32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_SR,        32'hffff_ffff, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_DR,        32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_CR1,       32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_CR1,       32'hffff_ffff, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        // transmitter shutdown, walked after the random traffic
        '{'{CMD_WRITE,   IDX_CR1,       32'h0000_20f4, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_SR,        32'hffff_fc9f, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_DR,        32'h0000_00a5, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_WRITE,   IDX_DR,        32'h0000_015a, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_SR,        32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_IDLE,    IDX_SR,        32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_SR,        32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_CR2,       32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_DR,        32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0},
        '{'{CMD_READ,    IDX_BAD_FIRST, 32'h0000_0000, 8'h00}, 1'b0, 32'h0, 1'b0, 1'b0}
    };

    usart_register_status_model #(
        .RX_FIFO_DEPTH(RX_DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_reg_index   (s_reg_index),
        .s_write_data  (s_write_data),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_tx_valid    (m_tx_valid),
        .m_tx_byte     (m_tx_byte),
        .m_irq         (m_irq),
        .m_dma_request (m_dma_request),
        .m_rx_dropped  (m_rx_dropped),
        .m_last        (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic receiver_on();
        return regs_m[REG_CR1][CR1_UE] & regs_m[REG_CR1][CR1_RE];
    endfunction

    function automatic logic irq_from_flags();
        logic [31:0] sr;
        logic [31:0] c1;
        sr = regs_m[REG_SR];
        c1 = regs_m[REG_CR1];
        return (sr[SR_TC] & c1[CR1_TCIE]) | (sr[SR_IDLE] & c1[CR1_IDLEIE]) |
               (sr[SR_TXE] & c1[CR1_TXEIE]) |
               (c1[CR1_RXNEIE] & (sr[SR_ORE] | sr[SR_RXNE]));
    endfunction

    function automatic void refill_rdr();
        logic [7:0] b;
        if (rx_fifo_m.size() == 0)
            return;
        if (receiver_on() && regs_m[REG_SR][SR_RXNE])
            return;
        b = rx_fifo_m.pop_front();
        if (receiver_on()) begin
            if (regs_m[REG_SR][SR_RXNE]) begin
                regs_m[REG_SR][SR_ORE] = 1'b1;
                seen_ore_m = 1'b0;
            end
            regs_m[REG_DR] = (regs_m[REG_DR] & ~DR_DATA_MASK) | {24'd0, b};
            regs_m[REG_SR][SR_RXNE] = 1'b1;
        end
    endfunction

    // updates the predicted state and queues the responses of one request
    function automatic int predict_usart_response(input item_t it);
        logic [31:0] wd;
        logic [31:0] v;
        logic [31:0] rdata;
        logic [7:0]  txb [2];
        logic        dropped;
        int          ntx;
        int          n;
        usart_resp_t r;
        wd = it.write_data;
        rdata = 32'd0;
        dropped = 1'b0;
        ntx = 0;
        txb[0] = 8'd0;
        txb[1] = 8'd0;
        case (it.command)
            CMD_READ: begin
                if (it.reg_index < 4'(NUM_REGS)) begin
                    if (it.reg_index == IDX_SR) begin
                        if (regs_m[REG_SR][SR_ORE])
                            seen_ore_m = 1'b1;
                        if (regs_m[REG_SR][SR_IDLE])
                            seen_idle_m = 1'b1;
                        rdata = regs_m[REG_SR];
                    end else if (it.reg_index == IDX_DR) begin
                        if (regs_m[REG_SR][SR_ORE] && seen_ore_m)
                            regs_m[REG_SR][SR_ORE] = 1'b0;
                        if (seen_idle_m) begin
                            regs_m[REG_SR][SR_IDLE] = 1'b0;
                            seen_idle_m = 1'b0;
                        end
                        if (regs_m[REG_SR][SR_RXNE]) begin
                            regs_m[REG_SR][SR_RXNE] = 1'b0;
                            rdata = {24'd0, regs_m[REG_DR][7:0]};
                            refill_rdr();
                        end else begin
                            regs_m[REG_DR] = regs_m[REG_DR] & ~DR_DATA_MASK;
                        end
                    end else begin
                        seen_idle_m = 1'b0;
                        rdata = regs_m[it.reg_index[2:0]];
                    end
                end
            end
            CMD_WRITE: begin
                if (it.reg_index < 4'(NUM_REGS)) begin
                    if (it.reg_index == IDX_SR) begin
                        if ((wd & ~regs_m[REG_SR] & SR_CLEAR_ONLY) != 32'd0)
                            wd = wd | SR_CLEAR_ONLY;
                        regs_m[REG_SR] = regs_m[REG_SR] & wd;
                    end else if (it.reg_index == IDX_DR) begin
                        v = wd & DR_DATA_MASK;
                        if (regs_m[REG_SR][SR_TC]) begin
                            txb[ntx] = v[7:0];
                            ntx++;
                            if (!regs_m[REG_SR][SR_TXE]) begin
                                txb[ntx] = tx_hold_m[7:0];
                                ntx++;
                            end
                            regs_m[REG_SR][SR_TXE] = 1'b1;
                            regs_m[REG_SR][SR_TC] = 1'b1;
                        end else if (regs_m[REG_SR][SR_TXE]) begin
                            tx_hold_m = v[8:0];
                            regs_m[REG_SR][SR_TXE] = 1'b0;
                        end
                    end else begin
                        regs_m[it.reg_index[2:0]] = wd;
                    end
                end
            end
            CMD_RX_BYTE: begin
                if (rx_fifo_m.size() < RX_DEPTH)
                    rx_fifo_m.push_back(it.rx_byte);
                else
                    dropped = 1'b1;
                if (rx_fifo_m.size() > fifo_peak)
                    fifo_peak = rx_fifo_m.size();
                refill_rdr();
            end
            CMD_IDLE: begin
                regs_m[REG_SR][SR_IDLE] = 1'b1;
            end
            default: begin
            end
        endcase
        n = (ntx > 0) ? ntx : 1;
        for (int k = 0; k < n; k++) begin
            r.read_data   = rdata;
            r.tx_valid    = (k < ntx);
            r.tx_byte     = (k < ntx) ? txb[k] : 8'd0;
            r.irq         = irq_from_flags();
            r.dma_request = regs_m[REG_SR][SR_RXNE] & regs_m[REG_CR3][CR3_DMAR];
            r.rx_dropped  = dropped;
            r.last        = (k == n - 1);
            pending_resp_q.push_back(r);
        end
        return n;
    endfunction

    task automatic send_request(input item_t it, input logic typed, input usart_resp_t want);
        int n;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_command    <= it.command;
        s_reg_index  <= it.reg_index;
        s_write_data <= it.write_data;
        s_rx_byte    <= it.rx_byte;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        n = predict_usart_response(it);
        if (typed) begin
            repeat (n) void'(pending_resp_q.pop_back());
            pending_resp_q.push_back(want);
        end
        request_count++;
    endtask

    task automatic pause_input(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic send_dir_rows(input int first, input int stop);
        usart_resp_t want;
        for (int i = first; i < stop; i++) begin
            want = '{dir_rows[i].want_rd, 1'b0, 8'd0, dir_rows[i].want_irq,
                     dir_rows[i].want_dma, 1'b0, 1'b1};
            send_request(dir_rows[i].req, dir_rows[i].typed, want);
        end
    endtask

    task automatic send_random(input cmd_t c, input logic [3:0] idx);
        item_t it;
        it.command    = c;
        it.reg_index  = idx;
        it.write_data = $urandom;
        it.rx_byte    = 8'($urandom_range(0, 255));
        // keep tc alive until the quiet tail so the transmit path stays reachable
        if (c == CMD_WRITE && idx == IDX_SR && !calm)
            it.write_data[SR_TC] = 1'b1;
        if (c == CMD_WRITE && idx == IDX_CR1 && $urandom_range(0, 4) != 0) begin
            it.write_data[CR1_UE] = 1'b1;
            it.write_data[CR1_RE] = 1'b1;
        end
        if (!calm && $urandom_range(0, 6) == 0)
            pause_input($urandom_range(1, 14));
        send_request(it, 1'b0, '0);
    endtask

    // result side stalls
    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 14);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_resp = '{m_read_data, m_tx_valid, m_tx_byte, m_irq, m_dma_request,
                         m_rx_dropped, m_last};
            result_count++;
            if (got_resp.tx_valid)
                tx_count++;
            if (got_resp.rx_dropped)
                drop_count++;
            if (pending_resp_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("extra response: rd %h tx %b %h irq %b dma %b drop %b last %b",
                             got_resp.read_data, got_resp.tx_valid, got_resp.tx_byte,
                             got_resp.irq, got_resp.dma_request, got_resp.rx_dropped,
                             got_resp.last);
            end else begin
                want_resp = pending_resp_q.pop_front();
                if (got_resp !== want_resp) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch (exp/got): rd %h/%h tx %b %h/%b %h",
                                 want_resp.read_data, got_resp.read_data,
                                 want_resp.tx_valid, want_resp.tx_byte,
                                 got_resp.tx_valid, got_resp.tx_byte);
                        $display("  irq %b/%b dma %b/%b drop %b/%b last %b/%b",
                                 want_resp.irq, got_resp.irq,
                                 want_resp.dma_request, got_resp.dma_request,
                                 want_resp.rx_dropped, got_resp.rx_dropped,
                                 want_resp.last, got_resp.last);
                    end
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_REGS; i++)
            regs_m[i] = 32'd0;
        regs_m[REG_SR] = SR_RESET;
        tx_hold_m   = 9'd0;
        seen_ore_m  = 1'b0;
        seen_idle_m = 1'b0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_dir_rows(0, SHUTDOWN_ROW);

        while (request_count < SHUTDOWN_ROW + RANDOM_ITEMS) begin
            calm = (request_count >= SHUTDOWN_ROW + RANDOM_ITEMS - QUIET_ITEMS);
            case ($urandom_range(0, 5))
                0: begin
                    // receive burst, often enough to fill the fifo
                    repeat ($urandom_range(4, 20))
                        send_random(CMD_RX_BYTE, 4'($urandom_range(0, 15)));
                end
                1: begin
                    repeat ($urandom_range(2, 12)) begin
                        if ($urandom_range(0, 2) == 0)
                            send_random(CMD_READ, IDX_SR);
                        send_random(CMD_READ, IDX_DR);
                    end
                end
                2: begin
                    // idle event, maybe status read, data read may clear it
                    send_random(CMD_IDLE, 4'($urandom_range(0, 15)));
                    if ($urandom_range(0, 3) != 0)
                        send_random(CMD_READ, IDX_SR);
                    if ($urandom_range(0, 3) == 0)
                        send_random(CMD_READ, 4'($urandom_range(IDX_BRR, IDX_GTPR)));
                    send_random(CMD_READ, IDX_DR);
                end
                3: begin
                    repeat ($urandom_range(2, 6))
                        send_random($urandom_range(0, 1) ? CMD_READ : CMD_WRITE,
                                    4'($urandom_range(0, 15)));
                end
                4: begin
                    repeat ($urandom_range(1, 4))
                        send_random(CMD_WRITE, IDX_DR);
                end
                default: begin
                    repeat ($urandom_range(1, 6))
                        send_random(cmd_t'($urandom_range(0, 3)),
                                    4'($urandom_range(0, 15)));
                end
            endcase
        end

        calm = 1'b1;
        send_dir_rows(SHUTDOWN_ROW, NUM_DIR);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_resp_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d requests, %0d responses, %0d bytes sent, %0d receive drops",
                 request_count, result_count, tx_count, drop_count);
        $display("tb: receive fifo peak %0d of %0d, %0d mismatches",
                 fifo_peak, RX_DEPTH, mismatch_count);
        if (mismatch_count == 0 && pending_resp_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/usrsm_pkg.sv
src/usrsm_rx_fifo.sv
src/usrsm_core.sv
src/usrsm_out_stage.sv
src/usart_register_status_model.sv
tb/usart_register_status_model_tb.sv
